>>> hdl/wfac_pkg.sv
// Package: types, constants and rate table for the frame airtime calculator.
package wfac_pkg;

   localparam int ACTION_W  = 2;
   localparam int RATE_W    = 16;
   localparam int BYTES_W   = 16;
   localparam int DUR_W     = 30;
   localparam int NUM_W     = 29;
   localparam int DEN_W     = 16;
   localparam int REM_W     = DEN_W;
   localparam int NDBPS_W   = 8;
   localparam int OFS_W     = 8;
   localparam int OFDM_NUM_W = 20;
   localparam int TABLE_N   = 8;

   localparam int unsigned FHSS_PRE_US   = 32 + 96;
   localparam int unsigned DSSS_SHORT_US = 72 + 24;
   localparam int unsigned DSSS_LONG_US  = 144 + 48;
   localparam int unsigned OFDM_PRE_US   = 16 + 4;
   localparam int unsigned DOFDM_PRE_US  = 8 + 4;
   localparam int unsigned DOFDM_EXT_US  = 6;
   localparam int unsigned OFDM_OVH_BITS = 16 + 6;
   localparam int unsigned KBPS_PER_MBPS = 1000;
   localparam int unsigned BITS_SCALE    = 8 * KBPS_PER_MBPS;

   localparam int unsigned OFDM_MBPS  [TABLE_N] = '{6, 9, 12, 18, 24, 36, 48, 54};
   localparam int unsigned OFDM_NDBPS [TABLE_N] = '{24, 36, 48, 72, 96, 144, 192, 216};

   typedef enum logic [ACTION_W-1:0] {
      MODE_FHSS  = 2'd0,
      MODE_DSSS  = 2'd1,
      MODE_OFDM  = 2'd2,
      MODE_DOFDM = 2'd3
   } mode_type;

   typedef struct packed {
      logic             invalid;
      logic             sym4;
      logic [OFS_W-1:0] offset;
   } side_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      side_type         side;
   } div_type;

   function automatic logic [NDBPS_W-1:0] lookup_ndbps(input logic [RATE_W-1:0] rate);
      logic [NDBPS_W-1:0] nd;
      nd = '0;
      for (int k = 0; k < TABLE_N; k++) begin
         if ((32'(rate) >= OFDM_MBPS[k] * KBPS_PER_MBPS) &&
             (32'(rate) < (OFDM_MBPS[k] + 1) * KBPS_PER_MBPS)) begin
            nd = NDBPS_W'(OFDM_NDBPS[k]);
         end
      end
      return nd;
   endfunction

endpackage

>>> hdl/wfac_if.sv
// Interfaces: request and response channels of the frame airtime calculator.
interface wfac_req_if import wfac_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [RATE_W-1:0]   rate_kbps;
   logic [BYTES_W-1:0]  frame_bytes;
   logic                short_pre;

   modport source (output valid, action, rate_kbps, frame_bytes, short_pre,
                   input ready);
   modport sink   (input valid, action, rate_kbps, frame_bytes, short_pre,
                   output ready);
endinterface

interface wfac_rsp_if import wfac_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [DUR_W-1:0] duration_us;
   logic             rate_invalid;

   modport source (output valid, duration_us, rate_invalid, input ready);
   modport sink   (input valid, duration_us, rate_invalid, output ready);
endinterface

>>> hdl/wireless_frame_airtime_calc_top.sv
// Top level: frame airtime calculator, front end, bit-serial divider pipeline, back end.
//
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   action, rate_kbps, frame_bytes, short_pre
//   rsp_chan  out  valid/ready   duration_us, rate_invalid
//
// One transaction enters per cycle unless a downstream stall holds the pipeline; stages:
// two front-end stages, one divider stage per quotient bit (29), one result stage.
// The 29-bit numerator width sets the divider depth.
// Synchronous reset empties all stages; no clearing pass.
// Each stage stalls only when full and its successor is blocked, so bubbles collapse.
module wireless_frame_airtime_calc_top import wfac_pkg::*; (
   input logic          clock,
   input logic          reset,
   wfac_req_if.sink     req_chan,
   wfac_rsp_if.source   rsp_chan
);

   logic    stg_valid [NUM_W+1];
   logic    stg_ready [NUM_W+1];
   div_type stg_data  [NUM_W+1];

   wfac_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_chan.valid),
      .in_ready       (req_chan.ready),
      .action         (req_chan.action),
      .rate_kbps      (req_chan.rate_kbps),
      .frame_bytes    (req_chan.frame_bytes),
      .short_pre      (req_chan.short_pre),
      .out_valid      (stg_valid[0]),
      .out_ready      (stg_ready[0]),
      .out_data       (stg_data[0])
   );

   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      wfac_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_ready  (stg_ready[k]),
         .in_data   (stg_data[k]),
         .out_valid (stg_valid[k+1]),
         .out_ready (stg_ready[k+1]),
         .out_data  (stg_data[k+1])
      );
   end

   wfac_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (stg_valid[NUM_W]),
      .in_ready     (stg_ready[NUM_W]),
      .in_data      (stg_data[NUM_W]),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .duration_us  (rsp_chan.duration_us),
      .rate_invalid (rsp_chan.rate_invalid)
   );

endmodule

>>> hdl/wfac_front.sv
// Front end: mode decode, bit scaling, rate lookup and ceiling bias in two stages.
module wfac_front import wfac_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [ACTION_W-1:0] action,
   input  logic [RATE_W-1:0]   rate_kbps,
   input  logic [BYTES_W-1:0]  frame_bytes,
   input  logic                short_pre,
   output logic                out_valid,
   input  logic                out_ready,
   output div_type             out_data
);

   logic                  a_valid_ff, a_valid_in;
   logic [NUM_W-1:0]      a_prod_ff, a_prod_in;
   logic [OFDM_NUM_W-1:0] a_onum_ff, a_onum_in;
   logic [RATE_W-1:0]     a_rate_ff;
   logic [NDBPS_W-1:0]    a_nd_ff, a_nd_in;
   side_type              a_side_ff, a_side_in;
   logic                  a_ready;

   logic                  b_valid_ff, b_valid_in;
   div_type               b_data_ff, b_data_in;
   logic                  b_ready;

   logic [OFS_W-1:0]      dsss_pre;
   mode_type              mode;
   logic [DEN_W-1:0]      den;
   logic [NUM_W:0]        biased;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   always_comb begin
      mode      = mode_type'(action);
      dsss_pre  = short_pre ? OFS_W'(DSSS_SHORT_US) : OFS_W'(DSSS_LONG_US);
      a_prod_in = NUM_W'(32'(frame_bytes) * BITS_SCALE);
      a_onum_in = OFDM_NUM_W'({frame_bytes, 3'b000}) + OFDM_NUM_W'(OFDM_OVH_BITS);
      a_nd_in   = lookup_ndbps(rate_kbps);
      a_side_in = '0;
      case (mode)
         MODE_FHSS: begin
            a_side_in.offset  = OFS_W'(FHSS_PRE_US);
            a_side_in.invalid = (rate_kbps == '0);
         end
         MODE_DSSS: begin
            a_side_in.offset  = dsss_pre;
            a_side_in.invalid = (rate_kbps == '0);
         end
         MODE_OFDM: begin
            a_side_in.offset  = OFS_W'(OFDM_PRE_US);
            a_side_in.sym4    = 1'b1;
            a_side_in.invalid = (a_nd_in == '0);
         end
         MODE_DOFDM: begin
            a_side_in.offset  = dsss_pre + OFS_W'(DOFDM_PRE_US + DOFDM_EXT_US);
            a_side_in.sym4    = 1'b1;
            a_side_in.invalid = (a_nd_in == '0);
         end
         default: begin
            a_side_in.invalid = 1'b1;
         end
      endcase
   end

   always_comb begin
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      if (a_side_ff.invalid) begin
         den = DEN_W'(1);
      end else if (a_side_ff.sym4) begin
         den = DEN_W'(a_nd_ff);
      end else begin
         den = a_rate_ff;
      end
      if (a_side_ff.sym4) begin
         biased = (NUM_W + 1)'(a_onum_ff) + (NUM_W + 1)'(den) - (NUM_W + 1)'(1);
      end else begin
         biased = (NUM_W + 1)'(a_prod_ff) + (NUM_W + 1)'(den) - (NUM_W + 1)'(1);
      end
      b_data_in.rem  = '0;
      b_data_in.num  = biased[NUM_W-1:0];
      b_data_in.den  = den;
      b_data_in.side = a_side_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_prod_ff <= a_prod_in;
         a_onum_ff <= a_onum_in;
         a_rate_ff <= rate_kbps;
         a_nd_ff   <= a_nd_in;
         a_side_ff <= a_side_in;
      end
      if (b_ready) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

>>> hdl/wfac_div_step.sv
// Divider stage: one restoring quotient bit per register stage.
module wfac_div_step import wfac_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic             valid_ff, valid_in;
   div_type          data_ff, data_in;
   logic [REM_W:0]   rem_sh;
   logic [REM_W+1:0] diff;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      rem_sh   = {in_data.rem, in_data.num[NUM_W-1]};
      diff     = {1'b0, rem_sh} - {2'b00, in_data.den};
      data_in  = in_data;
      if (!diff[REM_W+1]) begin
         data_in.rem = diff[REM_W-1:0];
         data_in.num = {in_data.num[NUM_W-2:0], 1'b1};
      end else begin
         data_in.rem = rem_sh[REM_W-1:0];
         data_in.num = {in_data.num[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

`ifndef ASSERT_OFF
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.rem < data_ff.den))
      else $error("remainder not below divisor");
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.den != '0))
      else $error("zero divisor in divider stage");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(data_ff)))
      else $error("stalled stage lost or changed its transaction");
`endif

endmodule

>>> hdl/wfac_back.sv
// Back end: symbol scaling, preamble add and result register.
module wfac_back import wfac_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  div_type          in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [DUR_W-1:0] duration_us,
   output logic             rate_invalid
);

   logic             valid_ff, valid_in;
   logic [DUR_W-1:0] dur_ff, dur_in;
   logic             bad_ff;
   logic [DUR_W-1:0] q_scaled;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      if (in_data.side.sym4) begin
         q_scaled = {in_data.num[DUR_W-3:0], 2'b00};
      end else begin
         q_scaled = DUR_W'(in_data.num);
      end
      if (in_data.side.invalid) begin
         dur_in = '0;
      end else begin
         dur_in = q_scaled + DUR_W'(in_data.side.offset);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         dur_ff <= dur_in;
         bad_ff <= in_data.side.invalid;
      end
   end

   assign out_valid    = valid_ff;
   assign duration_us  = dur_ff;
   assign rate_invalid = bad_ff;

endmodule
